### rtl/core/assert_macros.svh
// Assertion macros for the port checker in rtl/core/lbsg_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AST_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define AST_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### rtl/core/lbsg_pkg.sv
// Shared types, constants and tables for the lidar ball finder.
// No dependencies.
`default_nettype none
package lbsg_pkg;

  localparam int GridColsDef = 13;
  localparam int GridRowsDef = 20;
  localparam int CellMmDef   = 400;

  localparam int InTdataW  = 32;
  localparam int OutTdataW = 48;
  localparam int CfgW      = 21;
  localparam int CfgIdxW   = 2;

  localparam int DistW = 14;
  localparam int AngW  = 16;
  localparam int TW    = 28;  // angle in Q.16 degrees
  localparam int XyW   = 20;  // CORDIC x/y, signed Q3.16
  localparam int ProdW = DistW + 1 + XyW;
  localparam int SumW  = 40;
  localparam int NW    = 24;  // divider dividend width
  localparam int CellW = 16;
  localparam int OutCellW = 13;
  localparam int CntW  = 8;
  localparam int ItW   = 4;
  localparam int CordicSteps = 16;

  localparam logic [AngW-1:0] AngEdgeLo = 16'd512;
  localparam logic [AngW-1:0] AngEdgeHi = 16'd19200;
  localparam logic [AngW-1:0] AngEnd    = 16'd19584;
  localparam logic [DistW-1:0] DistEdge = 14'd5000;
  localparam logic [DistW-1:0] DistMax  = 14'd1200;
  localparam int ArcMin = 1000 * 128;
  localparam int ArcMax = 4500 * 128;

  localparam logic signed [TW-1:0] TFull    = 28'sd23592960;
  localparam logic signed [TW-1:0] THalf    = 28'sd11796480;
  localparam logic signed [TW-1:0] TQuarter = 28'sd5898240;
  localparam logic signed [TW-1:0] TMount   = 28'sd2628456;
  localparam logic signed [XyW-1:0] CordicGain = 20'sd39797;
  localparam int MountMm = 250;

  typedef enum logic [1:0] {
    REG_POSE_X   = 2'd0,
    REG_POSE_Y   = 2'd1,
    REG_HEADING  = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_REDUCE, S_ITER, S_STORE,
    S_MULX, S_MULY, S_SUM, S_DLOAD, S_DIV, S_GRD, S_GWR, S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic ang_load;
    logic ang_sel;
    logic red_step;
    logic iter;
    logic store;
    logic mul;
    logic mul_sel;
    logic sum;
    logic div_load;
    logic div_step;
    logic grid_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic clr_last;
    logic red_done;
    logic it_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [TW-1:0] atan_q16(input logic [ItW-1:0] i);
    logic signed [TW-1:0] r;
    case (i)
      4'd0:  r = 28'sd2949120;
      4'd1:  r = 28'sd1740967;
      4'd2:  r = 28'sd919879;
      4'd3:  r = 28'sd466945;
      4'd4:  r = 28'sd234379;
      4'd5:  r = 28'sd117304;
      4'd6:  r = 28'sd58665;
      4'd7:  r = 28'sd29335;
      4'd8:  r = 28'sd14668;
      4'd9:  r = 28'sd7334;
      4'd10: r = 28'sd3667;
      4'd11: r = 28'sd1833;
      4'd12: r = 28'sd917;
      4'd13: r = 28'sd458;
      4'd14: r = 28'sd229;
      4'd15: r = 28'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/lbsg_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module lbsg_ram #(
  parameter int Width = 8,
  parameter int Depth = 260,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/lbsg_ctrl.sv
// Sequencer for the ball finder: grid clear, item intake, CORDIC passes,
// position math, cell division, grid update and result hand-off. Uses lbsg_pkg.
`default_nettype none
module lbsg_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire lbsg_pkg::dp_stat_t stat_i,
  output lbsg_pkg::dp_cmd_t       cmd_o
);
  import lbsg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    case (state_q)
      S_CLEAR:  if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (s_axis_tvalid && stat_i.emit) begin
          state_d = S_LOAD;
          pass_d  = 1'b0;
        end
      end
      S_LOAD:   state_d = S_REDUCE;
      S_REDUCE: if (stat_i.red_done) state_d = S_ITER;
      S_ITER:   if (stat_i.it_last) state_d = S_STORE;
      S_STORE: begin
        if (pass_q) begin
          state_d = S_MULX;
        end else begin
          pass_d  = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_MULX:   state_d = S_MULY;
      S_MULY:   state_d = S_SUM;
      S_SUM:    state_d = S_DLOAD;
      S_DLOAD:  state_d = S_DIV;
      S_DIV:    state_d = S_GRD;
      S_GRD:    state_d = S_GWR;
      S_GWR:    state_d = S_OUT;
      S_OUT:    if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    cmd_o.ang_sel = pass_q;
    case (state_q)
      S_CLEAR:  cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
      end
      S_LOAD:   cmd_o.ang_load = 1'b1;
      S_REDUCE: cmd_o.red_step = 1'b1;
      S_ITER:   cmd_o.iter = 1'b1;
      S_STORE:  cmd_o.store = 1'b1;
      S_MULX:   cmd_o.mul = 1'b1;
      S_MULY: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = 1'b1;
      end
      S_SUM:    cmd_o.sum = 1'b1;
      S_DLOAD:  cmd_o.div_load = 1'b1;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_GRD:    cmd_o.clr_wr = 1'b0;
      S_GWR:    cmd_o.grid_wr = 1'b1;
      S_OUT:    cmd_o.out_load = stat_i.out_free;
      default:  cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/lbsg_dp.sv
// Datapath: scan and segment state, shared CORDIC, position multiply,
// cell divider, grid RAM port and output register. Uses lbsg_pkg, lbsg_ram.
`default_nettype none
module lbsg_dp #(
  parameter int GRID_COLS = lbsg_pkg::GridColsDef,
  parameter int GRID_ROWS = lbsg_pkg::GridRowsDef,
  parameter int CELL_MM   = lbsg_pkg::CellMmDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lbsg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lbsg_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic [lbsg_pkg::InTdataW-1:0] s_axis_tdata,
  input  wire logic                          s_axis_tuser,
  input  wire logic                          m_axis_tready,
  output logic                               m_axis_tvalid,
  output logic [lbsg_pkg::OutTdataW-1:0]     m_axis_tdata,
  output logic                               m_axis_tuser,
  input  wire lbsg_pkg::dp_cmd_t             cmd_i,
  output lbsg_pkg::dp_stat_t                 stat_o
);
  import lbsg_pkg::*;

  localparam int Depth = GRID_COLS * GRID_ROWS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [NW-1:0] HalfCell = NW'(CELL_MM / 2);
  // floor(n / CELL_MM) = (n * RecM) >> RecK, exact for every n below 2**NW
  localparam int RecK = NW + $clog2(CELL_MM);
  localparam longint RecOne = longint'(1) << RecK;
  localparam logic [NW:0] RecM =
    (NW+1)'((RecOne + longint'(CELL_MM) - 1) / longint'(CELL_MM));

  // ---------------- configuration ----------------
  logic signed [CfgW-1:0] pose_x_q, pose_y_q;
  logic signed [9:0]      head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q <= '0;
      pose_y_q <= '0;
      head_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POSE_X:  pose_x_q <= cfg_data_i;
        REG_POSE_Y:  pose_y_q <= cfg_data_i;
        REG_HEADING: head_q   <= cfg_data_i[9:0];
        default:     head_q   <= head_q;
      endcase
    end
  end

  // ---------------- per-point segment logic ----------------
  logic [DistW-1:0] pd_q, pd_e, pd_n;
  logic [AngW-1:0]  pa_q, pa_e, pa_n, sa_q, sa_e, sa_n;
  logic [7:0]       run_q, run_e, run_n, balls_q, balls_e, balls_n;
  logic             open_q, open_e, open_n, done_q, done_e, done_n;
  logic             emit;
  logic             start;
  logic [15:0]      draw;
  logic [AngW-1:0]  ang;
  logic [DistW-1:0] pt_dist;
  logic [19:0]      l20, d19, d21, d23, d17;
  logic signed [AngW:0]   arc_diff;
  logic signed [31:0]     arc_prod;
  logic             in_run, jump;

  assign start = s_axis_tuser;
  assign draw  = s_axis_tdata[15:0];
  assign ang   = s_axis_tdata[31:16];

  always_comb begin
    pd_e    = start ? '0 : pd_q;
    pa_e    = start ? '0 : pa_q;
    sa_e    = start ? '0 : sa_q;
    run_e   = start ? '0 : run_q;
    open_e  = start ? 1'b0 : open_q;
    done_e  = start ? 1'b0 : done_q;
    balls_e = start ? '0 : balls_q;

    pt_dist = ((ang < AngEdgeLo) || (ang > AngEdgeHi)) ? DistEdge : draw[15:2];
    l20  = 20'(pd_e) * 20'd20;
    d19  = 20'(pt_dist) * 20'd19;
    d21  = 20'(pt_dist) * 20'd21;
    d23  = 20'(pt_dist) * 20'd23;
    d17  = 20'(pt_dist) * 20'd17;
    in_run = (l20 > d19) && (l20 < d21);
    jump   = (l20 > d23) || (l20 < d17);
    arc_diff = $signed({1'b0, pa_e}) - $signed({1'b0, sa_e});
    arc_prod = 32'($signed({1'b0, pd_e}) * arc_diff);

    pd_n = pd_e; pa_n = pa_e; sa_n = sa_e; run_n = run_e;
    open_n = open_e; done_n = done_e; balls_n = balls_e;
    emit = 1'b0;
    if (!done_e) begin
      if ((draw == '0) && (ang == '0)) begin
        done_n = 1'b1;
      end else if (ang > AngEnd) begin
        done_n = 1'b1;
      end else begin
        if (open_e) begin
          if (in_run) begin
            run_n = run_e + 8'd1;
          end else begin
            if ((run_e > 8'd1) && (pd_e < DistMax) &&
                (arc_prod > 32'(ArcMin)) && (arc_prod < 32'(ArcMax))) begin
              emit    = 1'b1;
              balls_n = balls_e + 8'd1;
            end
            open_n = 1'b0;
            sa_n   = '0;
            run_n  = '0;
          end
        end
        if (jump) begin
          open_n = 1'b1;
          sa_n   = ang;
          run_n  = '0;
        end
        pd_n = pt_dist;
        pa_n = ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pd_q <= '0; pa_q <= '0; sa_q <= '0; run_q <= '0;
      open_q <= 1'b0; done_q <= 1'b0; balls_q <= '0;
    end else if (cmd_i.accept) begin
      pd_q <= pd_n; pa_q <= pa_n; sa_q <= sa_n; run_q <= run_n;
      open_q <= open_n; done_q <= done_n; balls_q <= balls_n;
    end
  end

  // snapshot of the last point of the run, taken when the next point closes it
  logic [DistW-1:0] e_ld_q;
  logic [AngW-1:0]  e_pa_q;
  logic [7:0]       e_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && emit) begin
      e_ld_q  <= pd_e;
      e_pa_q  <= pa_e;
      e_idx_q <= balls_e;
    end
  end

  // ---------------- CORDIC ----------------
  logic signed [TW-1:0]  t_q, t1, t2, hq;
  logic signed [XyW-1:0] x_q, y_q, c1_q, s1_q, c2_q, s2_q, xs, ys;
  logic                  flip_q;
  logic [ItW-1:0]        it_q;

  assign hq = {{(TW-26){head_q[9]}}, head_q, 16'd0};
  assign t1 = $signed({{(TW-AngW-9){1'b0}}, e_pa_q, 9'd0}) - hq;
  assign t2 = TMount + hq;
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ang_load) begin
      t_q    <= cmd_i.ang_sel ? t2 : t1;
      x_q    <= CordicGain;
      y_q    <= '0;
      flip_q <= 1'b0;
      it_q   <= '0;
    end else if (cmd_i.red_step) begin
      if (t_q >= THalf) begin
        t_q <= t_q - TFull;
      end else if (t_q < -THalf) begin
        t_q <= t_q + TFull;
      end else if (t_q > TQuarter) begin
        t_q    <= t_q - THalf;
        flip_q <= 1'b1;
      end else if (t_q < -TQuarter) begin
        t_q    <= t_q + THalf;
        flip_q <= 1'b1;
      end
    end else if (cmd_i.iter) begin
      if (!t_q[TW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        t_q <= t_q - atan_q16(it_q);
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        t_q <= t_q + atan_q16(it_q);
      end
      it_q <= it_q + 1'b1;
    end
    if (cmd_i.store) begin
      if (cmd_i.ang_sel) begin
        c2_q <= flip_q ? -x_q : x_q;
        s2_q <= flip_q ? -y_q : y_q;
      end else begin
        c1_q <= flip_q ? -x_q : x_q;
        s1_q <= flip_q ? -y_q : y_q;
      end
    end
  end

  // ---------------- world position ----------------
  logic signed [ProdW-1:0] prx_q, pry_q, prod;
  logic signed [SumW-1:0]  vx_q, vy_q;

  assign prod = $signed({1'b0, e_ld_q}) * (cmd_i.mul_sel ? c1_q : s1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      if (cmd_i.mul_sel) pry_q <= prod;
      else               prx_q <= prod;
    end
    if (cmd_i.sum) begin
      vx_q <= SumW'(prx_q) + (SumW'(pose_x_q) <<< 16) + SumW'(c2_q) * SumW'(MountMm);
      vy_q <= SumW'(pry_q) + (SumW'(pose_y_q) <<< 16) + SumW'(s2_q) * SumW'(MountMm);
    end
  end

  // ---------------- cell division, reciprocal multiply per lane ------
  logic [NW-1:0]   nx_q, ny_q, qx_q, qy_q;
  logic            negx_q, negy_q;
  logic [SumW-1:0] ax, ay;
  logic [2*NW:0]   qpx, qpy;

  assign ax  = vx_q[SumW-1] ? SumW'(-vx_q) : SumW'(vx_q);
  assign ay  = vy_q[SumW-1] ? SumW'(-vy_q) : SumW'(vy_q);
  assign qpx = (2*NW+1)'(nx_q) * (2*NW+1)'(RecM);
  assign qpy = (2*NW+1)'(ny_q) * (2*NW+1)'(RecM);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      negx_q <= vx_q[SumW-1];
      negy_q <= vy_q[SumW-1];
      nx_q   <= vx_q[SumW-1] ? ax[16 +: NW] : ax[16 +: NW] + HalfCell;
      ny_q   <= vy_q[SumW-1] ? ay[16 +: NW] : ay[16 +: NW] + HalfCell;
    end else if (cmd_i.div_step) begin
      qx_q <= NW'(qpx >> RecK);
      qy_q <= NW'(qpy >> RecK);
    end
  end

  logic signed [CellW-1:0] cx, cy;
  logic                    in_map;

  assign cx = negx_q ? -$signed({1'b0, qx_q[CellW-2:0]}) : $signed({1'b0, qx_q[CellW-2:0]});
  assign cy = negy_q ? -$signed({1'b0, qy_q[CellW-2:0]}) : $signed({1'b0, qy_q[CellW-2:0]});
  assign in_map = !cx[CellW-1] && !cy[CellW-1] &&
                  (cx < $signed(CellW'(GRID_COLS))) && (cy < $signed(CellW'(GRID_ROWS)));

  // ---------------- grid ----------------
  logic [AW-1:0]   gaddr, clr_q, waddr;
  logic [CntW-1:0] rdata, wdata, cnt_q;
  logic            we, inmap_q;

  assign gaddr = AW'(cx * CellW'(GRID_ROWS) + cy);
  assign we    = cmd_i.clr_wr || (cmd_i.grid_wr && in_map);
  assign waddr = cmd_i.clr_wr ? clr_q : gaddr;
  assign wdata = cmd_i.clr_wr ? '0 : rdata + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  lbsg_ram #(.Width(CntW), .Depth(Depth), .AddrW(AW)) u_grid (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (gaddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.grid_wr) begin
      inmap_q <= in_map;
      cnt_q   <= in_map ? wdata : '0;
    end
  end

  // ---------------- output register ----------------
  logic out_v_q;
  logic [OutTdataW-1:0] out_d_q;
  logic out_u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_d_q <= {6'd0, cnt_q, e_idx_q, cy[OutCellW-1:0], cx[OutCellW-1:0]};
      out_u_q <= inmap_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = out_u_q;

  assign stat_o.emit     = emit;
  assign stat_o.clr_last = clr_q == AW'(Depth - 1);
  assign stat_o.red_done = (t_q <= TQuarter) && (t_q >= -TQuarter);
  assign stat_o.it_last  = it_q == ItW'(CordicSteps - 1);
  assign stat_o.out_free = !out_v_q || m_axis_tready;
endmodule
`default_nettype wire

### rtl/core/lidar_ball_segment_grid_unit.sv
// Top level of the lidar ball finder with occupancy grid.
// Uses lbsg_pkg, lbsg_ctrl, lbsg_dp (which holds lbsg_ram).
//
// Points are taken one word at a time. A point that closes no qualifying run
// leaves the block ready for the next word. A point that yields a ball is
// followed by two passes of one shared 16-step CORDIC (each a load, angle
// reduction, 16 iterations and a store), two multiplies, the position sum, a
// load and a reciprocal multiply for the cell division, a grid read, a grid
// write and the hand-off to the output register, which waits while the
// previous result is still held there. The block accepts no point while that
// work runs. After reset the grid RAM is cleared one entry per cycle, all
// GRID_COLS*GRID_ROWS entries (260 by default), before the first point is
// taken.
`default_nettype none
module lidar_ball_segment_grid_unit #(
  parameter int GRID_COLS = lbsg_pkg::GridColsDef,
  parameter int GRID_ROWS = lbsg_pkg::GridRowsDef,
  parameter int CELL_MM   = lbsg_pkg::CellMmDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lbsg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [lbsg_pkg::CfgW-1:0]      cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // distance_raw [15:0], angle_raw [31:16]
  input  wire logic [lbsg_pkg::InTdataW-1:0]  s_axis_tdata,
  // scan_start
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // cell_x [12:0], cell_y [25:13], ball_index [33:26], cell_count [41:34]
  output logic [lbsg_pkg::OutTdataW-1:0]      m_axis_tdata,
  // in_map
  output logic                                m_axis_tuser
);
  import lbsg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lbsg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  lbsg_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CELL_MM   (CELL_MM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );
endmodule
`default_nettype wire

### rtl/core/lbsg_checker.sv
// Port-level checks for the ball finder, bound to the top level.
// Uses assert_macros.svh and lbsg_pkg.
`default_nettype none
`include "assert_macros.svh"
module lbsg_port_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [lbsg_pkg::OutTdataW-1:0]    m_axis_tdata,
  input wire logic                              m_axis_tuser
);
  `AST_RST(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
  `AST_RST(a_off_map_zero, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[41:34] == 8'd0))
  `AST_RST(a_on_map_pos, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tdata[12] && !m_axis_tdata[25]))
  `AST_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> (!m_axis_tvalid && !s_axis_tready))
endmodule

bind lidar_ball_segment_grid_unit lbsg_port_checker u_lbsg_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### tb/lbsg_checker.sv
// Checker for lidar_ball_segment_grid_unit: snoops the config port and both streams,
// predicts each ball cell and compares it with the output words.
// Depends on lbsg_pkg.
module lbsg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [20:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          pending_o,
  output int          fails_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lbsg_pkg::*;

  localparam int Cols = 13;
  localparam int Rows = 20;
  localparam int CellMm = 400;
  localparam longint FullT = 360 * 65536;
  localparam longint HalfT = 180 * 65536;
  localparam longint QuartT = 90 * 65536;

  typedef struct packed {
    logic [12:0] cell_x;
    logic [12:0] cell_y;
    logic        in_map;
    logic [7:0]  ball_index;
    logic [7:0]  cell_count;
  } ball_t;

  ball_t balls_due[$];

  longint pose_x, pose_y, heading;
  logic [13:0] last_dist;
  logic [15:0] last_ang, seg_start;
  logic [7:0]  run_len, ball_num;
  bit          seg_open, scan_over;
  logic [7:0]  grid [Cols*Rows];

  assign pending_o = balls_due.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("lbsg_checker: %s mismatch got %0d want %0d at %0t", what, got, want, $time);
    fails_o++;
  endtask

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    x = 39797; y = 0; flip = 0;
    ang = ang % FullT;
    if (ang < 0) ang += FullT;
    if (ang >= HalfT) ang -= FullT;
    if (ang > QuartT) begin
      ang -= HalfT; flip = 1;
    end else if (ang < -QuartT) begin
      ang += HalfT; flip = 1;
    end
    z = ang;
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(atan_q16(i[3:0]));
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(atan_q16(i[3:0]));
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x; s = y;
  endfunction

  // Q.16 mm sum -> mm toward zero -> cell: round half up if >= 0, else truncate
  function automatic longint mm_to_cell(input longint q16);
    longint mm, q, r;
    mm = (q16 >= 0) ? (q16 >>> 16) : -((-q16) >>> 16);
    q = mm / CellMm;
    r = mm % CellMm;
    return (r < CellMm / 2) ? q : q + 1;
  endfunction

  function automatic ball_t locate_ball();
    ball_t b;
    longint c1, s1, c2, s2, hq, cx, cy;
    int k;
    hq = heading * 65536;
    sin_cos((longint'(last_ang) << 9) - hq, c1, s1);
    sin_cos(longint'(TMount) + hq, c2, s2);
    cx = mm_to_cell(longint'(last_dist) * s1 + pose_x * 65536 + 250 * c2);
    cy = mm_to_cell(longint'(last_dist) * c1 + pose_y * 65536 + 250 * s2);
    b = '0;
    if (cx >= 0 && cx < Cols && cy >= 0 && cy < Rows) begin
      k = int'(cx) * Rows + int'(cy);
      grid[k] = grid[k] + 8'd1;
      b.in_map = 1;
      b.cell_count = grid[k];
    end
    b.cell_x = cx[12:0];
    b.cell_y = cy[12:0];
    b.ball_index = ball_num;
    ball_num = ball_num + 8'd1;
    return b;
  endfunction

  task automatic take_point(input bit start, input logic [15:0] draw, input logic [15:0] ang);
    int unsigned d, ld;
    longint arc;
    if (start) begin
      last_dist = '0; last_ang = '0; seg_start = '0; run_len = '0;
      seg_open = 0; scan_over = 0; ball_num = '0;
    end
    if (scan_over) return;
    if (draw == 0 && ang == 0) begin
      scan_over = 1; return;
    end
    d = draw >> 2;
    ld = last_dist;
    if (ang < AngEdgeLo || ang > AngEdgeHi) d = DistEdge;
    if (ang > AngEnd) begin
      scan_over = 1; return;
    end
    if (seg_open) begin
      if (20 * ld > 19 * d && 20 * ld < 21 * d) begin
        run_len = run_len + 8'd1;
      end else begin
        arc = longint'(ld) * (longint'(last_ang) - longint'(seg_start));
        if (run_len > 1 && ld < DistMax && arc > ArcMin && arc < ArcMax)
          balls_due.push_back(locate_ball());
        seg_open = 0; seg_start = '0; run_len = '0;
      end
    end
    if (20 * ld > 23 * d || 20 * ld < 17 * d) begin
      seg_open = 1; seg_start = ang; run_len = '0;
    end
    last_dist = d[13:0];
    last_ang = ang;
  endtask

  initial fails_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x = 0; pose_y = 0; heading = 0;
      last_dist = '0; last_ang = '0; seg_start = '0; run_len = '0;
      seg_open = 0; scan_over = 0; ball_num = '0;
      foreach (grid[i]) grid[i] = '0;
      balls_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POSE_X:  pose_x = longint'($signed(cfg_data_i));
          REG_POSE_Y:  pose_y = longint'($signed(cfg_data_i));
          REG_HEADING: heading = longint'($signed(cfg_data_i[9:0]));
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        ball_t got, want;
        got = {m_tdata_i[12:0], m_tdata_i[25:13], m_tuser_i, m_tdata_i[33:26],
               m_tdata_i[41:34]};
        if (balls_due.size() == 0) begin
          $display("lbsg_checker: unexpected word %h at %0t", m_tdata_i, $time);
          fails_o++;
        end else begin
          want = balls_due.pop_front();
          if (got.cell_x !== want.cell_x) report("cell_x", got.cell_x, want.cell_x);
          if (got.cell_y !== want.cell_y) report("cell_y", got.cell_y, want.cell_y);
          if (got.in_map !== want.in_map) report("in_map", got.in_map, want.in_map);
          if (got.ball_index !== want.ball_index)
            report("ball_index", got.ball_index, want.ball_index);
          if (got.cell_count !== want.cell_count)
            report("cell_count", got.cell_count, want.cell_count);
        end
      end
      if (s_tvalid_i && s_tready_i)
        take_point(s_tuser_i, s_tdata_i[15:0], s_tdata_i[31:16]);
    end
  end
endmodule

### tb/tb_top.sv
// Stimulus and verdict for lidar_ball_segment_grid_unit; checking lives in lbsg_checker.
// Depends on lbsg_pkg, the block's RTL and tb/lbsg_checker.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lbsg_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int Drain = 120;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [20:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 0, s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid, m_axis_tready = 0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          pending, fails;
  int          burst_left = 0, points_sent = 0, stall_mode = 0, stall_left = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  lidar_ball_segment_grid_unit uut (.*);

  lbsg_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .pending_o(pending), .fails_o(fails)
  );

  // receiver: always ready, never ready-ish, or coin flips, in stretches
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 300);
    end
    stall_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= $urandom_range(0, 1);
    endcase
  end

  task automatic send_point(input bit start, input logic [15:0] draw, input logic [15:0] ang);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= start;
    s_axis_tdata <= {ang, draw};
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_pose(input int px, input int py, input int hd);
    write_reg(REG_POSE_X, px[20:0]);
    write_reg(REG_POSE_Y, py[20:0]);
    write_reg(REG_HEADING, {11'd0, hd[9:0]});
  endtask

  function automatic logic [15:0] raw_dist(input int mm);
    return 16'((mm << 2) | $urandom_range(0, 3));
  endfunction

  // one scan: balls (far, near run, far) mixed with noise, usually closed off
  task automatic run_scan();
    int a, dn, step, len;
    a = $urandom_range(512, 900);
    send_point(1'b1, raw_dist($urandom_range(2500, 6000)), a[15:0]);
    while (a < 18000 && points_sent < 1000) begin
      if ($urandom_range(0, 4) != 0) begin
        dn = $urandom_range(200, 1250);
        step = $urandom_range(15, 140);
        len = $urandom_range(1, 10);
        a += $urandom_range(5, 60);
        send_point(1'b0, raw_dist(dn), a[15:0]);
        for (int i = 0; i < len && a < 18800; i++) begin
          a += step;
          send_point(1'b0, raw_dist(dn + $urandom_range(0, 2) - 1), a[15:0]);
        end
        a += step;
        send_point(1'b0, raw_dist($urandom_range(1600, 9000)), a[15:0]);
      end else begin
        a += $urandom_range(1, 200);
        send_point($urandom_range(0, 30) == 0, 16'($urandom), a[15:0]);
      end
    end
    case ($urandom_range(0, 3))
      0: send_point(1'b0, 16'd0, 16'd0);
      1: send_point(1'b0, 16'($urandom), 16'($urandom_range(19585, 65535)));
      2: send_point(1'b0, 16'($urandom), 16'($urandom));
      default: ;
    endcase
    send_point(1'b0, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_pose(2600, 3000, 0);
    // edges of the angle and distance fields, zero word, end marker
    send_point(1'b1, 16'hFFFF, 16'd511);
    send_point(1'b0, 16'd0, 16'd512);
    send_point(1'b0, 16'hFFFF, 16'd19200);
    send_point(1'b0, 16'd3200, 16'd19201);
    send_point(1'b0, 16'd0, 16'd1000);
    send_point(1'b0, 16'd3200, 16'd1040);
    send_point(1'b0, 16'd3200, 16'd1080);
    send_point(1'b0, 16'd3200, 16'd19584);
    send_point(1'b0, 16'd3204, 16'd19585);
    send_point(1'b0, 16'd4000, 16'd2000);
    send_point(1'b1, 16'd20000, 16'd600);
    send_point(1'b0, 16'd3200, 16'd700);
    send_point(1'b0, 16'd3200, 16'd800);
    send_point(1'b0, 16'd3204, 16'd900);
    send_point(1'b0, 16'd3200, 16'd1000);
    send_point(1'b0, 16'd20000, 16'd1100);
    send_point(1'b0, 16'd0, 16'd0);
    send_point(1'b0, 16'hFFFF, 16'hFFFF);
    send_point(1'b1, 16'hFFFF, 16'hFFFF);
    wait_idle();
    write_reg(RegUnused, 21'h1FFFFF);
    set_pose(-1000000, -1000000, -360);
    run_scan();
    wait_idle();
    set_pose(1000000, 1000000, 360);
    run_scan();
    while (points_sent < 1000) begin
      wait_idle();
      if ($urandom_range(0, 5) == 0)
        set_pose($urandom_range(0, 2000000) - 1000000, $urandom_range(0, 2000000) - 1000000,
                 $urandom_range(0, 720) - 360);
      else
        set_pose($urandom_range(0, 5200), $urandom_range(0, 8000),
                 $urandom_range(0, 720) - 360);
      run_scan();
    end
    wait_idle();
    if (fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
